/* rtl/wsmc_pkg.sv */
package wsmc_pkg;

   typedef enum logic [1:0] {
      ST_RUNNING  = 2'd0,
      ST_COMPLETE = 2'd1,
      ST_FAILED   = 2'd2,
      ST_IDLE     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      FLT_NONE       = 3'd0,
      FLT_WRONG_DIR  = 3'd1,
      FLT_OVER_LIMIT = 3'd2,
      FLT_MISMATCH   = 3'd3,
      FLT_TIMEOUT    = 3'd4,
      FLT_STALL      = 3'd5
   } fault_type;

   typedef enum logic [1:0] {
      MODE_OFF       = 2'd0,
      MODE_FORWARD   = 2'd1,
      MODE_CLOCKWISE = 2'd2
   } mode_type;

   localparam logic REQ_START  = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   localparam logic KIND_FORWARD = 1'b0;

   localparam logic [1:0] CSR_FWD_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_TURN_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_WINDOW_MS = 2'd2;
   localparam logic [1:0] CSR_STALL_LIMIT = 2'd3;

   localparam logic [15:0] FWD_TIMEOUT_RESET = 16'd10000;
   localparam logic [15:0] TURN_TIMEOUT_RESET = 16'd6000;
   localparam logic [15:0] WINDOW_MS_RESET = 16'd300;
   localparam logic [3:0] STALL_LIMIT_RESET = 4'd4;

   // Duty values and thresholds of the forward and turn profiles.
   localparam int WRONG_DIR_LIMIT = -10;
   localparam int OVER_FWD = 100;
   localparam int OVER_TURN = 60;
   localparam int MISMATCH_FWD = 80;
   localparam int MISMATCH_TURN = 50;
   localparam int STALL_ADVANCE = 2;
   localparam logic [6:0] BASE_LEFT_FWD = 7'd50;
   localparam logic [6:0] BASE_RIGHT_FWD = 7'd55;
   localparam logic [6:0] FAST_LEFT_TURN = 7'd58;
   localparam logic [6:0] FAST_RIGHT_TURN = 7'd63;
   localparam logic [6:0] MID_LEFT_TURN = 7'd50;
   localparam logic [6:0] MID_RIGHT_TURN = 7'd55;
   localparam logic [6:0] SLOW_LEFT_TURN = 7'd44;
   localparam logic [6:0] SLOW_RIGHT_TURN = 7'd49;
   localparam int TIER_FAST = 70;
   localparam int TIER_MID = 25;
   localparam int RAMP_UP_SPAN = 100;
   localparam int RAMP_DOWN_SPAN = 160;
   localparam int CORR_BIG = 60;
   localparam logic [3:0] CORR_LIM_FWD = 4'd15;
   localparam logic [3:0] CORR_LIM_TURN = 4'd12;
   localparam logic [6:0] PWM_LO_FWD = 7'd42;
   localparam logic [6:0] PWM_HI_FWD = 7'd100;
   localparam logic [6:0] PWM_LO_TURN = 7'd36;
   localparam logic [6:0] PWM_HI_TURN = 7'd90;

   typedef struct packed {
      logic       run;
      logic       fwd;
      status_type status;
      fault_type  fault;
      mode_type   mode;
      logic [15:0] target;
      logic [6:0] left_pwm;
      logic [6:0] right_pwm;
   } job_type;

   typedef struct packed {
      status_type status;
      fault_type  fault;
      logic [6:0] left_pwm;
      logic [6:0] right_pwm;
      mode_type   mode;
   } rsp_ctl_type;

   function automatic logic [3:0] bump_count(input logic [3:0] c);
      bump_count = (c == 4'd15) ? 4'd15 : c + 4'd1;
   endfunction

endpackage

/* rtl/wheel_segment_motion_controller_unit.sv */
// A request accepted into the job queue passes through the back end's stage registers
// into the result queue; it is held in place while the back end is stalled.
// Throughput: one request per cycle while the job queue is not full; the front end
// updates segment state per request and the back end is a three-stage duty pipeline.
// Reset (synchronous, active high) empties both queues, ends any segment and loads
// the default timeouts, window length and stall limit.
module wheel_segment_motion_controller_unit #(
   parameter int COUNT_BITS = 32,
   parameter int TIME_BITS = 32,
   parameter int JOB_DEPTH = 4,
   parameter int RSP_DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [1:0]                   csr_index,
   input  logic [15:0]                  csr_wdata,
   input  logic                         push,
   output logic                         full,
   input  logic                         req_type,
   input  logic                         req_motion_kind,
   input  logic [15:0]                  req_target_count,
   input  logic signed [COUNT_BITS-1:0] req_left_count,
   input  logic signed [COUNT_BITS-1:0] req_right_count,
   input  logic [TIME_BITS-1:0]         req_now_ms,
   input  logic                         pop,
   output logic                         empty,
   output logic [1:0]                   rsp_status,
   output logic [2:0]                   rsp_fault,
   output logic [6:0]                   rsp_left_pwm,
   output logic [6:0]                   rsp_right_pwm,
   output logic [1:0]                   rsp_drive_mode,
   output logic signed [COUNT_BITS-1:0] rsp_left_progress,
   output logic signed [COUNT_BITS-1:0] rsp_right_progress
);
   import wsmc_pkg::*;

   localparam int JOB_W = $bits(job_type) + 2 * COUNT_BITS;
   localparam int RSP_W = $bits(rsp_ctl_type) + 2 * COUNT_BITS;

   logic                         accept;
   job_type                      fe_job, be_job;
   logic signed [COUNT_BITS-1:0] fe_lp, fe_rp, be_lp, be_rp;
   logic [JOB_W-1:0]             jq_rd_data;
   logic                         jq_empty, jq_take;

   rsp_ctl_type                  out_ctl, head_ctl;
   logic signed [COUNT_BITS-1:0] out_lp, out_rp;
   logic                         out_valid, rq_full;
   logic [RSP_W-1:0]             rq_rd_data;

   assign accept = push && !full;

   wsmc_front #(
      .COUNT_BITS(COUNT_BITS),
      .TIME_BITS(TIME_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .accept(accept),
      .req_type(req_type),
      .req_motion_kind(req_motion_kind),
      .req_target_count(req_target_count),
      .req_left_count(req_left_count),
      .req_right_count(req_right_count),
      .req_now_ms(req_now_ms),
      .job(fe_job),
      .job_left_progress(fe_lp),
      .job_right_progress(fe_rp)
   );

   wsmc_queue #(
      .WIDTH(JOB_W),
      .DEPTH(JOB_DEPTH)
   ) u_job_queue (
      .clock(clock),
      .reset(reset),
      .wr_en(push),
      .wr_data({fe_job, fe_lp, fe_rp}),
      .rd_en(jq_take),
      .rd_data(jq_rd_data),
      .is_full(full),
      .is_empty(jq_empty)
   );

   assign {be_job, be_lp, be_rp} = jq_rd_data;

   wsmc_back #(
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .job_valid(!jq_empty),
      .job(be_job),
      .job_left_progress(be_lp),
      .job_right_progress(be_rp),
      .job_take(jq_take),
      .out_full(rq_full),
      .out_valid(out_valid),
      .out_ctl(out_ctl),
      .out_left_progress(out_lp),
      .out_right_progress(out_rp)
   );

   wsmc_queue #(
      .WIDTH(RSP_W),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .wr_en(out_valid),
      .wr_data({out_ctl, out_lp, out_rp}),
      .rd_en(pop),
      .rd_data(rq_rd_data),
      .is_full(rq_full),
      .is_empty(empty)
   );

   assign {head_ctl, rsp_left_progress, rsp_right_progress} = rq_rd_data;
   assign rsp_status = head_ctl.status;
   assign rsp_fault = head_ctl.fault;
   assign rsp_left_pwm = head_ctl.left_pwm;
   assign rsp_right_pwm = head_ctl.right_pwm;
   assign rsp_drive_mode = head_ctl.mode;

endmodule

/* rtl/wsmc_queue.sv */
module wsmc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             is_full,
   output logic             is_empty
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign is_full = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign do_wr = wr_en && !is_full;
   assign do_rd = rd_en && !is_empty;
   assign rd_data = mem[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_rd) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wptr_ff] <= wr_data;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count exceeds its depth");

endmodule

/* rtl/wsmc_front.sv */
module wsmc_front #(
   parameter int COUNT_BITS = 32,
   parameter int TIME_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [1:0]                   csr_index,
   input  logic [15:0]                  csr_wdata,
   input  logic                         accept,
   input  logic                         req_type,
   input  logic                         req_motion_kind,
   input  logic [15:0]                  req_target_count,
   input  logic signed [COUNT_BITS-1:0] req_left_count,
   input  logic signed [COUNT_BITS-1:0] req_right_count,
   input  logic [TIME_BITS-1:0]         req_now_ms,
   output wsmc_pkg::job_type            job,
   output logic signed [COUNT_BITS-1:0] job_left_progress,
   output logic signed [COUNT_BITS-1:0] job_right_progress
);
   import wsmc_pkg::*;

   localparam int EB = (COUNT_BITS > 17 ? COUNT_BITS : 17) + 2;
   localparam int TW = (TIME_BITS > 16 ? TIME_BITS : 16);
   localparam logic signed [EB-1:0] WRONG_LIM = EB'(WRONG_DIR_LIMIT);
   localparam logic signed [EB-1:0] ADV_LIM = EB'(STALL_ADVANCE);

   logic [15:0] fwd_timeout_ff, turn_timeout_ff, window_ms_ff;
   logic [3:0]  stall_limit_ff;

   logic                         active_ff, active_in;
   logic                         kind_ff, kind_in;
   logic [15:0]                  target_ff, target_in;
   logic signed [COUNT_BITS-1:0] left_zero_ff, left_zero_in;
   logic signed [COUNT_BITS-1:0] right_zero_ff, right_zero_in;
   logic [TIME_BITS-1:0]         seg_start_ff, seg_start_in;
   logic [TIME_BITS-1:0]         win_start_ff, win_start_in;
   logic signed [COUNT_BITS-1:0] left_mark_ff, left_mark_in;
   logic signed [COUNT_BITS-1:0] right_mark_ff, right_mark_in;
   logic [3:0]                   left_stall_ff, left_stall_in;
   logic [3:0]                   right_stall_ff, right_stall_in;

   logic signed [COUNT_BITS-1:0] ld, lp, rp;
   logic signed [EB-1:0]         lpx, rpx, tx, over_max, mis_max, diff, la, ra;
   logic [TIME_BITS-1:0]         el_seg, el_win;
   logic [15:0]                  timeout_sel;
   logic                         fwd, f_wrong, f_over, f_mis, reached, f_time, win_due;
   logic [3:0]                   left_cnt_new, right_cnt_new;
   logic                         stalled, win_take;
   fault_type                    fault;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_timeout_ff <= FWD_TIMEOUT_RESET;
         turn_timeout_ff <= TURN_TIMEOUT_RESET;
         window_ms_ff <= WINDOW_MS_RESET;
         stall_limit_ff <= STALL_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FWD_TIMEOUT: fwd_timeout_ff <= csr_wdata;
            CSR_TURN_TIMEOUT: turn_timeout_ff <= csr_wdata;
            CSR_WINDOW_MS: window_ms_ff <= csr_wdata;
            CSR_STALL_LIMIT: stall_limit_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Progress and checks of a sample against the running segment.
   assign fwd = (kind_ff == KIND_FORWARD);
   assign ld = req_left_count - left_zero_ff;
   assign lp = fwd ? ld : -ld;
   assign rp = req_right_count - right_zero_ff;
   assign lpx = EB'(lp);
   assign rpx = EB'(rp);
   assign tx = EB'(target_ff);
   assign over_max = tx + (fwd ? EB'(OVER_FWD) : EB'(OVER_TURN));
   assign mis_max = fwd ? EB'(MISMATCH_FWD) : EB'(MISMATCH_TURN);
   assign diff = lpx - rpx;

   assign f_wrong = (lpx < WRONG_LIM) || (rpx < WRONG_LIM);
   assign f_over = (lpx > over_max) || (rpx > over_max);
   assign f_mis = (diff > mis_max) || (diff < -mis_max);
   assign reached = (lpx >= tx) && (rpx >= tx);

   assign el_seg = req_now_ms - seg_start_ff;
   assign el_win = req_now_ms - win_start_ff;
   assign timeout_sel = fwd ? fwd_timeout_ff : turn_timeout_ff;
   assign f_time = TW'(el_seg) >= TW'(timeout_sel);
   assign win_due = TW'(el_win) >= TW'(window_ms_ff);

   assign la = lpx - EB'(left_mark_ff);
   assign ra = rpx - EB'(right_mark_ff);
   assign left_cnt_new = (lpx < tx) ? ((la < ADV_LIM) ? bump_count(left_stall_ff) : 4'd0)
                                    : 4'd0;
   assign right_cnt_new = (rpx < tx) ? ((ra < ADV_LIM) ? bump_count(right_stall_ff) : 4'd0)
                                     : 4'd0;
   assign stalled = (left_cnt_new >= stall_limit_ff) || (right_cnt_new >= stall_limit_ff);
   assign win_take = !f_wrong && !f_over && !f_mis && !reached && !f_time && win_due;

   always_comb begin
      if (f_wrong) begin
         fault = FLT_WRONG_DIR;
      end else if (f_over) begin
         fault = FLT_OVER_LIMIT;
      end else if (f_mis) begin
         fault = FLT_MISMATCH;
      end else if (reached) begin
         fault = FLT_NONE;
      end else if (f_time) begin
         fault = FLT_TIMEOUT;
      end else if (win_due && stalled) begin
         fault = FLT_STALL;
      end else begin
         fault = FLT_NONE;
      end
   end

   // Job handed to the back end; fixed results are settled here.
   always_comb begin
      job.run = 1'b0;
      job.fwd = fwd;
      job.status = ST_IDLE;
      job.fault = FLT_NONE;
      job.mode = MODE_OFF;
      job.target = target_ff;
      job.left_pwm = '0;
      job.right_pwm = '0;
      job_left_progress = '0;
      job_right_progress = '0;
      if (req_type == REQ_START) begin
         job.status = ST_RUNNING;
         if (req_motion_kind == KIND_FORWARD) begin
            job.mode = MODE_FORWARD;
            job.left_pwm = BASE_LEFT_FWD;
            job.right_pwm = BASE_RIGHT_FWD;
         end else begin
            job.mode = MODE_CLOCKWISE;
            job.left_pwm = FAST_LEFT_TURN;
            job.right_pwm = FAST_RIGHT_TURN;
         end
      end else if (active_ff) begin
         job_left_progress = lp;
         job_right_progress = rp;
         if (fault != FLT_NONE) begin
            job.status = ST_FAILED;
            job.fault = fault;
         end else if (reached) begin
            job.status = ST_COMPLETE;
         end else begin
            job.run = 1'b1;
            job.status = ST_RUNNING;
            job.mode = fwd ? MODE_FORWARD : MODE_CLOCKWISE;
         end
      end
   end

   // Segment state update.
   always_comb begin
      active_in = active_ff;
      kind_in = kind_ff;
      target_in = target_ff;
      left_zero_in = left_zero_ff;
      right_zero_in = right_zero_ff;
      seg_start_in = seg_start_ff;
      win_start_in = win_start_ff;
      left_mark_in = left_mark_ff;
      right_mark_in = right_mark_ff;
      left_stall_in = left_stall_ff;
      right_stall_in = right_stall_ff;
      if (accept) begin
         if (req_type == REQ_START) begin
            active_in = 1'b1;
            kind_in = req_motion_kind;
            target_in = req_target_count;
            left_zero_in = req_left_count;
            right_zero_in = req_right_count;
            seg_start_in = req_now_ms;
            win_start_in = req_now_ms;
            left_mark_in = '0;
            right_mark_in = '0;
            left_stall_in = '0;
            right_stall_in = '0;
         end else if (active_ff) begin
            if (fault != FLT_NONE || reached) begin
               active_in = 1'b0;
            end
            if (win_take) begin
               left_stall_in = left_cnt_new;
               right_stall_in = right_cnt_new;
               left_mark_in = lp;
               right_mark_in = rp;
               win_start_in = req_now_ms;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         left_stall_ff <= '0;
         right_stall_ff <= '0;
      end else begin
         active_ff <= active_in;
         left_stall_ff <= left_stall_in;
         right_stall_ff <= right_stall_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      target_ff <= target_in;
      left_zero_ff <= left_zero_in;
      right_zero_ff <= right_zero_in;
      seg_start_ff <= seg_start_in;
      win_start_ff <= win_start_in;
      left_mark_ff <= left_mark_in;
      right_mark_ff <= right_mark_in;
   end

   a_start_arms : assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == REQ_START) |=> active_ff)
      else $error("segment not active after a start request");

   a_stop_idles : assert property (@(posedge clock) disable iff (reset)
      (accept && (job.status == ST_FAILED || job.status == ST_COMPLETE)) |=> !active_ff)
      else $error("segment still active after a fault or completion");

   a_fault_status : assert property (@(posedge clock) disable iff (reset)
      accept |-> ((job.fault != FLT_NONE) == (job.status == ST_FAILED)))
      else $error("fault code and failed status disagree");

endmodule

/* rtl/wsmc_back.sv */
module wsmc_back #(
   parameter int COUNT_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   input  wsmc_pkg::job_type            job,
   input  logic signed [COUNT_BITS-1:0] job_left_progress,
   input  logic signed [COUNT_BITS-1:0] job_right_progress,
   output logic                         job_take,
   input  logic                         out_full,
   output logic                         out_valid,
   output wsmc_pkg::rsp_ctl_type        out_ctl,
   output logic signed [COUNT_BITS-1:0] out_left_progress,
   output logic signed [COUNT_BITS-1:0] out_right_progress
);
   import wsmc_pkg::*;

   localparam int EB = (COUNT_BITS > 17 ? COUNT_BITS : 17) + 2;

   logic adv1, adv2, adv3;
   logic v1_ff, v2_ff, v3_ff;

   // Stage 1: spread, sum and profile inputs.
   job_type                      s1_job_ff;
   logic signed [COUNT_BITS-1:0] s1_lp_ff, s1_rp_ff;
   logic signed [EB-1:0]         s1_diff_ff, s1_sum_ff;
   logic [6:0]                   s1_slow_ff, s1_slow_in;
   logic [7:0]                   s1_rem_ff, s1_rem_in;
   logic                         s1_ldone_ff, s1_rdone_ff;
   logic signed [EB-1:0]         lpx, rpx, tx, slow, lead, rem;

   // Stage 2: spread magnitude, turn midpoint and ramp term.
   job_type                      s2_job_ff;
   logic signed [COUNT_BITS-1:0] s2_lp_ff, s2_rp_ff;
   logic                         s2_neg_ff, s2_big_ff, s2_ldone_ff, s2_rdone_ff;
   logic [5:0]                   s2_mag_ff;
   logic signed [EB-1:0]         s2_half_ff;
   logic [4:0]                   s2_add_ff;
   logic signed [EB-1:0]         mag, sum_adj;
   logic [15:0]                  up_prod;
   logic [4:0]                   up_term, down_term;

   // Stage 3: base duty and clamped correction.
   job_type                      s3_job_ff;
   logic signed [COUNT_BITS-1:0] s3_lp_ff, s3_rp_ff;
   logic                         s3_ldone_ff, s3_rdone_ff;
   logic signed [4:0]            s3_corr_ff, corr_in;
   logic [6:0]                   s3_bl_ff, s3_br_ff, bl_in, br_in;
   logic signed [EB-1:0]         rem_turn;
   logic [11:0]                  div5_prod;
   logic [3:0]                   corr_mag;

   logic signed [8:0] lv, rv, lo9, hi9;
   logic [6:0]        lpwm, rpwm;

   assign adv3 = !v3_ff || !out_full;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign job_take = job_valid && adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= job_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   assign lpx = EB'(job_left_progress);
   assign rpx = EB'(job_right_progress);
   assign tx = EB'(job.target);
   assign slow = (lpx < rpx) ? lpx : rpx;
   assign lead = (lpx > rpx) ? lpx : rpx;
   assign rem = tx - lead;

   always_comb begin
      if (slow < 0) begin
         s1_slow_in = '0;
      end else if (slow > EB'(RAMP_UP_SPAN)) begin
         s1_slow_in = 7'(RAMP_UP_SPAN);
      end else begin
         s1_slow_in = slow[6:0];
      end
      if (rem < 0) begin
         s1_rem_in = '0;
      end else if (rem > EB'(RAMP_DOWN_SPAN)) begin
         s1_rem_in = 8'(RAMP_DOWN_SPAN);
      end else begin
         s1_rem_in = rem[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_job_ff <= job;
         s1_lp_ff <= job_left_progress;
         s1_rp_ff <= job_right_progress;
         s1_diff_ff <= lpx - rpx;
         s1_sum_ff <= lpx + rpx;
         s1_slow_ff <= s1_slow_in;
         s1_rem_ff <= s1_rem_in;
         s1_ldone_ff <= (lpx >= tx);
         s1_rdone_ff <= (rpx >= tx);
      end
   end

   // Ramp up is floor(3*s/10) by reciprocal (exact for 3*s up to 300);
   // ramp down is floor(3*r/16).
   assign mag = s1_diff_ff[EB-1] ? -s1_diff_ff : s1_diff_ff;
   assign sum_adj = s1_sum_ff + EB'({1'b0, s1_sum_ff[EB-1]});
   assign up_prod = 16'(9'(s1_slow_ff) * 9'd3) * 16'd205;
   assign up_term = 5'(up_prod >> 11);
   assign down_term = 5'((10'(s1_rem_ff) * 10'd3) >> 4);

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_job_ff <= s1_job_ff;
         s2_lp_ff <= s1_lp_ff;
         s2_rp_ff <= s1_rp_ff;
         s2_neg_ff <= s1_diff_ff[EB-1];
         s2_big_ff <= (mag >= EB'(CORR_BIG));
         s2_mag_ff <= mag[5:0];
         s2_half_ff <= sum_adj >>> 1;
         s2_add_ff <= (up_term < down_term) ? up_term : down_term;
         s2_ldone_ff <= s1_ldone_ff;
         s2_rdone_ff <= s1_rdone_ff;
      end
   end

   // Below the clamp point the spread is under 60, so m/5 = (m*52) >> 8 is exact.
   assign div5_prod = 12'(s2_mag_ff) * 12'd52;
   assign rem_turn = EB'(s2_job_ff.target) - s2_half_ff;

   always_comb begin
      if (s2_job_ff.fwd) begin
         corr_mag = s2_big_ff ? CORR_LIM_FWD : 4'(s2_mag_ff >> 2);
         bl_in = BASE_LEFT_FWD + 7'(s2_add_ff);
         br_in = BASE_RIGHT_FWD + 7'(s2_add_ff);
      end else begin
         corr_mag = s2_big_ff ? CORR_LIM_TURN : 4'(div5_prod >> 8);
         if (rem_turn > EB'(TIER_FAST)) begin
            bl_in = FAST_LEFT_TURN;
            br_in = FAST_RIGHT_TURN;
         end else if (rem_turn > EB'(TIER_MID)) begin
            bl_in = MID_LEFT_TURN;
            br_in = MID_RIGHT_TURN;
         end else begin
            bl_in = SLOW_LEFT_TURN;
            br_in = SLOW_RIGHT_TURN;
         end
      end
      corr_in = s2_neg_ff ? -signed'({1'b0, corr_mag}) : signed'({1'b0, corr_mag});
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_job_ff <= s2_job_ff;
         s3_lp_ff <= s2_lp_ff;
         s3_rp_ff <= s2_rp_ff;
         s3_corr_ff <= corr_in;
         s3_bl_ff <= bl_in;
         s3_br_ff <= br_in;
         s3_ldone_ff <= s2_ldone_ff;
         s3_rdone_ff <= s2_rdone_ff;
      end
   end

   assign lo9 = signed'({2'b00, s3_job_ff.fwd ? PWM_LO_FWD : PWM_LO_TURN});
   assign hi9 = signed'({2'b00, s3_job_ff.fwd ? PWM_HI_FWD : PWM_HI_TURN});
   assign lv = signed'({2'b00, s3_bl_ff}) - 9'(s3_corr_ff);
   assign rv = signed'({2'b00, s3_br_ff}) + 9'(s3_corr_ff);

   always_comb begin
      lpwm = s3_job_ff.left_pwm;
      rpwm = s3_job_ff.right_pwm;
      if (s3_job_ff.run) begin
         if (s3_ldone_ff) begin
            lpwm = '0;
         end else if (lv < lo9) begin
            lpwm = lo9[6:0];
         end else if (lv > hi9) begin
            lpwm = hi9[6:0];
         end else begin
            lpwm = lv[6:0];
         end
         if (s3_rdone_ff) begin
            rpwm = '0;
         end else if (rv < lo9) begin
            rpwm = lo9[6:0];
         end else if (rv > hi9) begin
            rpwm = hi9[6:0];
         end else begin
            rpwm = rv[6:0];
         end
      end
   end

   assign out_valid = v3_ff && !out_full;
   assign out_ctl.status = s3_job_ff.status;
   assign out_ctl.fault = s3_job_ff.fault;
   assign out_ctl.left_pwm = lpwm;
   assign out_ctl.right_pwm = rpwm;
   assign out_ctl.mode = s3_job_ff.mode;
   assign out_left_progress = s3_lp_ff;
   assign out_right_progress = s3_rp_ff;

   a_hold_on_full : assert property (@(posedge clock) disable iff (reset)
      (v3_ff && out_full) |=> (v3_ff && $stable(s3_lp_ff) && $stable(s3_corr_ff)))
      else $error("last stage changed while the result queue was full");

endmodule
